// File: src/cfs_pkg.sv
package cfs_pkg;

	localparam logic [7:0] QUOTE_CHAR  = 8'h22;
	localparam logic [7:0] SPACE_CHAR  = 8'h20;
	localparam logic [7:0] TAB_CHAR    = 8'h09;
	localparam logic [7:0] DELIM_RESET = 8'h2c;

	localparam int         ADDR_W       = 3;
	localparam logic [0:0] REG_DELIMITER = 1'b0;

	localparam logic KIND_CONTENT   = 1'b0;
	localparam logic KIND_FIELD_END = 1'b1;

	typedef struct packed {
		logic [7:0] char_in;
		logic       line_end;
	} in_word_t;

	typedef struct packed {
		logic       item_kind;
		logic [7:0] content_byte;
		logic [3:0] column_index;
		logic [5:0] field_length;
		logic       row_last;
		logic       was_truncated;
	} out_word_t;

endpackage

// File: src/csv_field_splitter_top.sv
// Splits CSV lines into fields: one character word in, at most one result word out, one
// word a cycle sustained while result_ready is high. A word sits in the input register
// while the parse state updates, then its result in the result register. Words with no
// result (skipped blanks, quotes, dropped bytes, discarded text) still pass the input
// register. Delimiter reg: byte address 0, resets to comma; write it only while idle.
module csv_field_splitter_top
	import cfs_pkg::*;
#(
	parameter int MAX_COLUMNS   = 16,
	parameter int MAX_VALUE_LEN = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_ready,
	input  in_word_t                 item,
	output logic                     result_valid,
	input  logic                     result_ready,
	output out_word_t                result,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [cfs_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	logic [7:0] delimiter;
	logic       res_valid;
	logic       res_ready;
	out_word_t  res;

	cfs_apb_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.delimiter (delimiter)
	);

	cfs_parser #(
		.MAX_COLUMNS   (MAX_COLUMNS),
		.MAX_VALUE_LEN (MAX_VALUE_LEN)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.delimiter  (delimiter),
		.res_ready  (res_ready),
		.res_valid  (res_valid),
		.res        (res)
	);

	cfs_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// File: src/cfs_apb_regs.sv
module cfs_apb_regs
	import cfs_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [cfs_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	output logic [7:0]               delimiter
);

	logic [7:0] delim_q;
	logic [0:0] reg_idx;

	assign reg_idx   = paddr[ADDR_W-1 -: 1];
	assign pready    = 1'b1;
	assign delimiter = delim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= DELIM_RESET;
		end else if (psel && penable && pwrite && pready && reg_idx == REG_DELIMITER) begin
			delim_q <= pwdata[7:0];
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DELIMITER: prdata = {24'd0, delim_q};
			default:       prdata = 32'd0;
		endcase
	end

endmodule

// File: src/cfs_parser.sv
module cfs_parser
	import cfs_pkg::*;
#(
	parameter int MAX_COLUMNS   = 16,
	parameter int MAX_VALUE_LEN = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_word_t  item,
	input  logic [7:0] delimiter,
	input  logic      res_ready,
	output logic      res_valid,
	output out_word_t res
);

	localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int LW = $clog2(MAX_VALUE_LEN);
	localparam logic [CW-1:0] COL_LAST = CW'(MAX_COLUMNS - 1);
	localparam logic [LW-1:0] LEN_MAX  = LW'(MAX_VALUE_LEN - 1);

	typedef enum logic [2:0] {
		MODE_START,
		MODE_PLAIN,
		MODE_QUOTED,
		MODE_PENDING,
		MODE_DISCARD
	} mode_t;

	logic     valid_s1;
	in_word_t item_s1;
	logic     advance;

	mode_t         mode_q, mode_d;
	logic [CW-1:0] col_q, col_d;
	logic [LW-1:0] len_q, len_d;
	logic          ovf_q, ovf_d;

	logic        emit;
	logic        do_plain, do_keep;
	logic [7:0]  c;
	logic        eol;
	logic [31:0] col_ext, len_ext;

	assign advance    = valid_s1 && res_ready;
	assign item_ready = !valid_s1 || res_ready;
	assign c          = item_s1.char_in;
	assign eol        = item_s1.line_end;
	assign col_ext    = 32'(col_q);
	assign res_valid  = advance && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_START;
			col_q  <= '0;
			len_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (advance) begin
			mode_q <= mode_d;
			col_q  <= col_d;
			len_q  <= len_d;
			ovf_q  <= ovf_d;
		end
	end

	always_comb begin
		mode_d   = mode_q;
		col_d    = col_q;
		len_d    = len_q;
		ovf_d    = ovf_q;
		emit     = 1'b0;
		do_plain = 1'b0;
		do_keep  = 1'b0;
		len_ext  = 32'(len_q);
		res      = '0;
		res.column_index = col_ext[3:0];

		if (mode_q == MODE_DISCARD) begin
			if (eol) begin
				mode_d = MODE_START;
				col_d  = '0;
				len_d  = '0;
				ovf_d  = 1'b0;
			end
		end else if (eol) begin
			emit              = 1'b1;
			res.item_kind     = KIND_FIELD_END;
			res.field_length  = len_ext[5:0];
			res.row_last      = 1'b1;
			res.was_truncated = ovf_q;
			mode_d = MODE_START;
			col_d  = '0;
			len_d  = '0;
			ovf_d  = 1'b0;
		end else begin
			case (mode_q)
				MODE_START: begin
					if (c == QUOTE_CHAR) begin
						mode_d = MODE_QUOTED;
					end else if (c != SPACE_CHAR && c != TAB_CHAR) begin
						do_plain = 1'b1;
					end
				end
				MODE_QUOTED: begin
					if (c == QUOTE_CHAR) begin
						mode_d = MODE_PENDING;
					end else begin
						do_keep = 1'b1;
					end
				end
				MODE_PENDING: begin
					// doubled quote is one literal quote, anything else closes quoting
					if (c == QUOTE_CHAR) begin
						mode_d  = MODE_QUOTED;
						do_keep = 1'b1;
					end else begin
						do_plain = 1'b1;
					end
				end
				default: do_plain = 1'b1;
			endcase

			if (do_plain) begin
				mode_d = MODE_PLAIN;
				if (c == delimiter) begin
					emit              = 1'b1;
					res.item_kind     = KIND_FIELD_END;
					res.field_length  = len_ext[5:0];
					res.row_last      = (col_q == COL_LAST);
					res.was_truncated = ovf_q;
					len_d = '0;
					ovf_d = 1'b0;
					if (col_q == COL_LAST) begin
						mode_d = MODE_DISCARD;
					end else begin
						col_d  = col_q + 1'b1;
						mode_d = MODE_START;
					end
				end else begin
					do_keep = 1'b1;
				end
			end

			if (do_keep) begin
				if (len_q != LEN_MAX) begin
					len_d            = len_q + 1'b1;
					emit             = 1'b1;
					res.item_kind    = KIND_CONTENT;
					res.content_byte = c;
				end else begin
					ovf_d = 1'b1;
				end
			end
		end
	end

`ifndef ASSERT_OFF
	a_discard_silent: assert property (@(posedge clk) disable iff (!arst_n)
		advance && mode_q == MODE_DISCARD |-> !res_valid)
		else $error("result produced while discarding rest of line");

	a_ovf_at_cap: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> len_q == LEN_MAX)
		else $error("truncation flag set below field capacity");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.item_kind == KIND_FIELD_END |=> len_q == '0 && !ovf_q)
		else $error("field counters not cleared after field end");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(len_q) && $stable(col_q) && $stable(mode_q))
		else $error("parser state moved without an item");
`endif

endmodule

// File: src/cfs_out_reg.sv
module cfs_out_reg
	import cfs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      res_valid,
	output logic      res_ready,
	input  out_word_t res,
	output logic      result_valid,
	input  logic      result_ready,
	output out_word_t result
);

	logic      valid_s2;
	out_word_t word_s2;

	assign res_ready    = !valid_s2 || result_ready;
	assign result_valid = valid_s2;
	assign result       = word_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (res_ready) begin
			valid_s2 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			word_s2 <= res;
		end
	end

endmodule

// File: tb/csv_splitter_checker.sv
`timescale 1ns / 1ps

// watches both word channels and the register port, predicts every result word
// of the splitter and compares it against what the block hands out
module csv_splitter_checker
	import cfs_pkg::*;
#(
	parameter int MAX_COLUMNS   = 16,
	parameter int MAX_VALUE_LEN = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                item_ready,
	input  in_word_t            item,
	input  logic                result_valid,
	input  logic                result_ready,
	input  out_word_t           result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [31:0]         pwdata,
	input  logic                pready,
	output int                  fail_count,
	output int                  pending_words,
	output int                  words_checked,
	output int                  fields_closed,
	output int                  fields_cut
);

	localparam logic [ADDR_W-1:0] DELIM_ADDR = ADDR_W'(4 * REG_DELIMITER);

	typedef enum logic [2:0] {
		AT_FIELD_START,
		IN_PLAIN,
		IN_QUOTES,
		QUOTE_SEEN,
		SKIP_TO_EOL
	} parse_state_t;

	parse_state_t pstate;
	int           col;
	int           kept;
	logic         dropped;
	logic [7:0]   delim;
	out_word_t    expected_words[$];

	function automatic out_word_t make_word(logic kind, logic [7:0] b, logic [5:0] len,
		logic last, logic trunc);
		out_word_t w;
		w.item_kind     = kind;
		w.content_byte  = b;
		w.column_index  = 4'(col);
		w.field_length  = len;
		w.row_last      = last;
		w.was_truncated = trunc;
		return w;
	endfunction

	task automatic start_line();
		pstate  = AT_FIELD_START;
		col     = 0;
		kept    = 0;
		dropped = 1'b0;
	endtask

	task automatic keep_char(logic [7:0] c);
		if (kept < MAX_VALUE_LEN - 1) begin
			kept++;
			expected_words.push_back(make_word(KIND_CONTENT, c, '0, 1'b0, 1'b0));
		end else begin
			dropped = 1'b1;
		end
	endtask

	task automatic close_field();
		logic last;
		last = (col + 1 >= MAX_COLUMNS);
		expected_words.push_back(make_word(KIND_FIELD_END, '0, 6'(kept), last, dropped));
		kept    = 0;
		dropped = 1'b0;
		if (last) begin
			pstate = SKIP_TO_EOL;
		end else begin
			col++;
			pstate = AT_FIELD_START;
		end
	endtask

	task automatic plain_char(logic [7:0] c);
		pstate = IN_PLAIN;
		if (c == delim) begin
			close_field();
		end else begin
			keep_char(c);
		end
	endtask

	task automatic predict_word(in_word_t w);
		logic [7:0] c;
		c = w.char_in;
		if (pstate == SKIP_TO_EOL) begin
			if (w.line_end) begin
				start_line();
			end
		end else if (w.line_end) begin
			// end of line closes whatever field is open, quoted or not
			expected_words.push_back(make_word(KIND_FIELD_END, '0, 6'(kept), 1'b1, dropped));
			start_line();
		end else begin
			case (pstate)
				AT_FIELD_START: begin
					if (c == QUOTE_CHAR) begin
						pstate = IN_QUOTES;
					end else if (c != SPACE_CHAR && c != TAB_CHAR) begin
						plain_char(c);
					end
				end
				IN_QUOTES: begin
					if (c == QUOTE_CHAR) begin
						pstate = QUOTE_SEEN;
					end else begin
						keep_char(c);
					end
				end
				QUOTE_SEEN: begin
					// doubled quote stays quoted, anything else drops out of quoting
					if (c == QUOTE_CHAR) begin
						pstate = IN_QUOTES;
						keep_char(c);
					end else begin
						plain_char(c);
					end
				end
				default: begin
					plain_char(c);
				end
			endcase
		end
	endtask

	task automatic note_failure(string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t: %s", $time, msg);
		end
	endtask

	function automatic string word_text(out_word_t w);
		return $sformatf("kind=%0d byte=%02h col=%0d len=%0d last=%0d trunc=%0d",
			w.item_kind, w.content_byte, w.column_index, w.field_length,
			w.row_last, w.was_truncated);
	endfunction

	task automatic check_word(out_word_t got);
		out_word_t want;
		if (expected_words.size() == 0) begin
			note_failure($sformatf("result word with nothing expected: %s", word_text(got)));
		end else begin
			want = expected_words.pop_front();
			words_checked++;
			if (want.item_kind == KIND_FIELD_END) begin
				fields_closed++;
				if (want.was_truncated) begin
					fields_cut++;
				end
			end
			if (got.item_kind !== want.item_kind || got.content_byte !== want.content_byte ||
				got.column_index !== want.column_index ||
				got.field_length !== want.field_length ||
				got.row_last !== want.row_last || got.was_truncated !== want.was_truncated) begin
				note_failure($sformatf("result mismatch: expected %s, got %s",
					word_text(want), word_text(got)));
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_line();
			delim = DELIM_RESET;
			expected_words.delete();
			fail_count    = 0;
			pending_words = 0;
			words_checked = 0;
			fields_closed = 0;
			fields_cut    = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == DELIM_ADDR) begin
				delim = pwdata[7:0];
			end
			// result first: a word leaving now was predicted at an earlier edge
			if (result_valid && result_ready) begin
				check_word(result);
			end
			if (item_valid && item_ready) begin
				predict_word(item);
			end
			pending_words = expected_words.size();
		end
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import cfs_pkg::*;

	localparam logic [ADDR_W-1:0] DELIM_ADDR = ADDR_W'(4 * REG_DELIMITER);
	localparam int NUM_PHASES    = 7;
	localparam int PHASE_WORDS   = 260;
	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_LIMIT   = 2000;
	localparam logic [7:0] DELIM_PLAN [NUM_PHASES] = '{
		DELIM_RESET, 8'h00, 8'h3b, SPACE_CHAR, 8'hff, TAB_CHAR, QUOTE_CHAR
	};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              item_valid;
	logic              item_ready;
	in_word_t          item;
	logic              result_valid;
	logic              result_ready;
	out_word_t         result;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	int fail_count;
	int pending_words;
	int words_checked;
	int fields_closed;
	int fields_cut;

	int         send_idle_pct;
	int         recv_idle_pct;
	bit         hold_now;
	bit         long_hold_done;
	int         words_sent;
	int         quiet_cycles;
	logic [7:0] cur_delim;
	in_word_t   line_words[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	csv_field_splitter_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	csv_splitter_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.fail_count   (fail_count),
		.pending_words(pending_words),
		.words_checked(words_checked),
		.fields_closed(fields_closed),
		.fields_cut   (fields_cut)
	);

	// result side: random stalls, plus one long hold-off to back the block up
	initial begin
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_now && !long_hold_done) begin
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				long_hold_done = 1'b1;
			end else begin
				result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) ||
			(psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", quiet_cycles);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic in_word_t char_word(logic [7:0] c);
		in_word_t w;
		w.char_in  = c;
		w.line_end = 1'b0;
		return w;
	endfunction

	function automatic in_word_t eol_word();
		in_word_t w;
		w.char_in  = 8'($urandom_range(0, 255));
		w.line_end = 1'b1;
		return w;
	endfunction

	function automatic logic [7:0] pick_content();
		logic [7:0] c;
		do begin
			if ($urandom_range(0, 1)) begin
				c = 8'($urandom_range(8'h61, 8'h7a));
			end else begin
				c = 8'($urandom_range(0, 255));
			end
		end while (c == cur_delim || c == QUOTE_CHAR);
		return c;
	endfunction

	task automatic push_text(ref in_word_t q[$], input string s);
		for (int i = 0; i < s.len(); i++) begin
			q.push_back(char_word(s[i]));
		end
	endtask

	// one line of fields: mostly well formed, with empty fields, quoting,
	// oversize fields, rows past the column limit and some raw noise
	task automatic build_line(ref in_word_t q[$]);
		int pick;
		int nfields;
		int flen;
		int kind;
		pick = $urandom_range(0, 15);
		if (pick == 0) begin
			nfields = 0;
		end else if (pick <= 2) begin
			nfields = $urandom_range(14, 20);
		end else begin
			nfields = $urandom_range(1, 6);
		end
		for (int f = 0; f < nfields; f++) begin
			if (f > 0) begin
				q.push_back(char_word(cur_delim));
			end
			kind = $urandom_range(0, 19);
			flen = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 75) : $urandom_range(0, 6);
			if ($urandom_range(0, 3) == 0) begin
				q.push_back(char_word($urandom_range(0, 1) ? SPACE_CHAR : TAB_CHAR));
			end
			if (kind < 10) begin
				repeat (flen) q.push_back(char_word(pick_content()));
			end else if (kind < 16) begin
				q.push_back(char_word(QUOTE_CHAR));
				repeat (flen) begin
					if ($urandom_range(0, 5) == 0) begin
						q.push_back(char_word(QUOTE_CHAR));
						q.push_back(char_word(QUOTE_CHAR));
					end else if ($urandom_range(0, 3) == 0) begin
						q.push_back(char_word(cur_delim));
					end else begin
						q.push_back(char_word(pick_content()));
					end
				end
				// last field sometimes left open up to end of line
				if (f != nfields - 1 || $urandom_range(0, 9) != 0) begin
					q.push_back(char_word(QUOTE_CHAR));
				end
				if ($urandom_range(0, 5) == 0) begin
					q.push_back(char_word(pick_content()));
				end
			end else if (kind >= 18) begin
				repeat ($urandom_range(1, 5)) q.push_back(char_word(8'($urandom_range(0, 255))));
			end
		end
		q.push_back(eol_word());
	endtask

	task automatic send_word(in_word_t w);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= w;
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic send_all(ref in_word_t q[$]);
		while (q.size() > 0) begin
			send_word(q.pop_front());
		end
	endtask

	task automatic drain(int settle);
		item_valid <= 1'b0;
		wait (pending_words == 0);
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_delimiter(logic [7:0] d);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= DELIM_ADDR;
		pwdata  <= {24'h0, d};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cur_delim = d;
	endtask

	initial begin
		int phase_start;
		arst_n        = 1'b0;
		item_valid    = 1'b0;
		item          = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		hold_now      = 1'b0;
		long_hold_done = 1'b0;
		words_sent    = 0;
		quiet_cycles  = 0;
		send_idle_pct = 38;
		recv_idle_pct = 70;
		cur_delim     = DELIM_RESET;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_delimiter(DELIM_RESET);
		// blanks, doubled quote, text after a closing quote, unclosed quote
		push_text(line_words, " \t\"a\"\"b\"c,\"d");
		line_words.push_back(eol_word());
		// closing quote followed by delimiter, then by end of line
		push_text(line_words, "\"q\",\"r\"");
		line_words.push_back(eol_word());
		// zero byte, all-ones byte, trailing delimiter, then an empty line
		line_words.push_back(char_word(8'h00));
		line_words.push_back(char_word(8'hff));
		line_words.push_back(char_word(DELIM_RESET));
		line_words.push_back(eol_word());
		line_words.push_back(eol_word());
		send_all(line_words);

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p < 3) begin
				send_idle_pct = 38;
				recv_idle_pct = 70;
			end else if (p < 5) begin
				send_idle_pct = 70;
				recv_idle_pct = 38;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (p > 0) begin
				drain(4);
				write_delimiter(DELIM_PLAN[p]);
			end
			if (p == 5) begin
				hold_now = 1'b1;
			end
			phase_start = words_sent;
			while (words_sent - phase_start < PHASE_WORDS) begin
				build_line(line_words);
				send_all(line_words);
			end
		end

		drain(20);
		$display("sent %0d input words over %0d delimiter settings, with stalls on both sides",
			words_sent, NUM_PHASES);
		$display("checked %0d result words: %0d field ends, %0d of them truncated",
			words_checked, fields_closed, fields_cut);
		if (fail_count == 0 && pending_words == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d failures, %0d results still expected", fail_count, pending_words);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
